// ===== design/xsr_pkg.sv =====
// Shared types and constants for the xoshiro256++ generator.
`default_nettype none

package xsr_pkg;

    localparam int WORD_W  = 64;
    localparam int NWORDS  = 4;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 8;
    localparam int SHIFT_T = 17;

    localparam logic [NWORDS*WORD_W-1:0] JUMP_POLY = {
        64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
        64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
    };

    localparam logic [IDX_W-1:0] MOD_LAST  = 8'd63;
    localparam logic [IDX_W-1:0] JUMP_LAST = 8'd255;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [NWORDS-1:0][WORD_W-1:0] t_state;

    typedef enum logic [OP_W-1:0] {
        OP_SEED   = 2'd0,
        OP_NEXT   = 2'd1,
        OP_RANGED = 2'd2,
        OP_FORK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_FIX,
        S_JUMP
    } t_fsm;

    typedef struct packed {
        logic             load;
        logic             mod_step;
        logic             mod_fix;
        logic             jump_step;
        logic             jump_last;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic range_direct;
    } t_dp_sts;

    function automatic t_word scramble(input t_state s);
        t_word sum;
        sum = s[0] + s[3];
        return {sum[40:0], sum[63:41]} + s[0];
    endfunction

    function automatic t_state advance(input t_state s);
        t_state n;
        t_word  t;
        t    = s[1] << SHIFT_T;
        n    = s;
        n[2] = n[2] ^ n[0];
        n[3] = n[3] ^ n[1];
        n[1] = n[1] ^ n[2];
        n[0] = n[0] ^ n[3];
        n[2] = n[2] ^ t;
        n[3] = {n[3][18:0], n[3][63:19]};
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== design/xoshiro256pp_generator_top.sv =====
// Top level of the xoshiro256++ generator with ranged output and 2^128 jump.
// Seed, next and ranged next with a single-value, inverted or full range: result valid in the cycle after accept.
// Ranged next with a proper span: result from the 64-step restoring modulo unit plus one add.
// Fork: result from the 256 steps of the jump sequencer.
// One transaction is in flight at a time; the next is taken once the result register frees.
// Synchronous reset clears the state words to zero and returns the controller to idle.
`default_nettype none

module xoshiro256pp_generator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [63:0] i_seed,
    input  wire logic [63:0] i_range_low,
    input  wire logic [63:0] i_range_high,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_value,
    output logic [63:0]      o_forked_word0,
    output logic [63:0]      o_forked_word1,
    output logic [63:0]      o_forked_word2,
    output logic [63:0]      o_forked_word3
);
    import xsr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    xsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_op    (i_op),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    xsr_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_op           (i_op),
        .i_seed         (i_seed),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_value        (o_value),
        .o_forked_word0 (o_forked_word0),
        .o_forked_word1 (o_forked_word1),
        .o_forked_word2 (o_forked_word2),
        .o_forked_word3 (o_forked_word3)
    );

endmodule

`default_nettype wire

// ===== design/xsr_datapath.sv =====
// Datapath: state words, jump accumulator, restoring modulo and result registers.
`default_nettype none

module xsr_datapath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire xsr_pkg::t_dp_cmd i_cmd,
    output xsr_pkg::t_dp_sts     o_sts,
    input  wire logic [1:0]      i_op,
    input  wire logic [63:0]     i_seed,
    input  wire logic [63:0]     i_range_low,
    input  wire logic [63:0]     i_range_high,
    output logic [63:0]          o_value,
    output logic [63:0]          o_forked_word0,
    output logic [63:0]          o_forked_word1,
    output logic [63:0]          o_forked_word2,
    output logic [63:0]          o_forked_word3
);
    import xsr_pkg::*;

    t_state r_s;
    t_state r_acc;
    t_word  r_div;
    t_word  r_rem;
    t_word  r_span;
    t_word  r_lo;
    t_word  r_value;
    t_state r_fork;

    t_word          raw;
    t_state         adv;
    t_word          span;
    logic           lo_ge_hi;
    logic [WORD_W:0] rem_sh;
    logic [WORD_W:0] rem_sub;
    t_state         acc_next;

    always_comb begin
        raw      = scramble(r_s);
        adv      = advance(r_s);
        span     = i_range_high - i_range_low + t_word'(1);
        lo_ge_hi = (i_range_low >= i_range_high);
        o_sts.range_direct = lo_ge_hi || (span == '0);
        rem_sh   = {r_rem, r_div[WORD_W-1]};
        rem_sub  = rem_sh - {1'b0, r_span};
        acc_next = JUMP_POLY[i_cmd.idx] ? (r_acc ^ r_s) : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else if (i_cmd.load) begin
            unique case (t_op'(i_op))
                OP_SEED: begin
                    r_s <= {NWORDS{i_seed}};
                end
                OP_NEXT: begin
                    r_s <= adv;
                end
                OP_RANGED: begin
                    if (!lo_ge_hi) begin
                        r_s <= adv;
                    end
                end
                OP_FORK: begin
                    r_s <= r_s;
                end
                default: begin
                    r_s <= r_s;
                end
            endcase
        end else if (i_cmd.jump_step) begin
            if (i_cmd.jump_last) begin
                r_s <= acc_next;
            end else begin
                r_s <= adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc  <= '0;
            r_div  <= raw;
            r_rem  <= '0;
            r_span <= span;
            r_lo   <= i_range_low;
            r_fork <= (t_op'(i_op) == OP_FORK) ? r_s : '0;
            unique case (t_op'(i_op))
                OP_NEXT: begin
                    r_value <= raw;
                end
                OP_RANGED: begin
                    r_value <= lo_ge_hi ? i_range_low : raw;
                end
                default: begin
                    r_value <= '0;
                end
            endcase
        end else begin
            if (i_cmd.jump_step) begin
                r_acc <= acc_next;
            end
            if (i_cmd.mod_step) begin
                r_div <= r_div << 1;
                if (!rem_sub[WORD_W]) begin
                    r_rem <= rem_sub[WORD_W-1:0];
                end else begin
                    r_rem <= rem_sh[WORD_W-1:0];
                end
            end
            if (i_cmd.mod_fix) begin
                r_value <= r_rem + r_lo;
            end
        end
    end

    assign o_value        = r_value;
    assign o_forked_word0 = r_fork[0];
    assign o_forked_word1 = r_fork[1];
    assign o_forked_word2 = r_fork[2];
    assign o_forked_word3 = r_fork[3];

endmodule

`default_nettype wire

// ===== design/xsr_ctrl.sv =====
// Controller: transaction handshake, step counter and sequencing of the datapath.
`default_nettype none

module xsr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [1:0]       i_op,
    output logic                  o_valid,
    input  wire logic             i_ready,
    input  wire xsr_pkg::t_dp_sts i_sts,
    output xsr_pkg::t_dp_cmd      o_cmd
);
    import xsr_pkg::*;

    t_fsm             r_state;
    t_fsm             n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             accept;
    logic             done_now;

    assign accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (t_op'(i_op) == OP_FORK) begin
                        n_state = S_JUMP;
                    end else if (t_op'(i_op) == OP_RANGED && !i_sts.range_direct) begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (r_idx == MOD_LAST) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_state = S_IDLE;
            end
            S_JUMP: begin
                if (r_idx == JUMP_LAST) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready         = (r_state == S_IDLE) && (!r_out_valid || i_ready);
        o_cmd.load      = accept;
        o_cmd.mod_step  = (r_state == S_MOD);
        o_cmd.mod_fix   = (r_state == S_FIX);
        o_cmd.jump_step = (r_state == S_JUMP);
        o_cmd.jump_last = (r_state == S_JUMP) && (r_idx == JUMP_LAST);
        o_cmd.idx       = r_idx;
        n_idx           = (r_state == S_MOD || r_state == S_JUMP) ? r_idx + 1'b1 : '0;
        done_now        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                done_now = accept && (t_op'(i_op) != OP_FORK) &&
                           !(t_op'(i_op) == OP_RANGED && !i_sts.range_direct);
            end
            S_FIX: begin
                done_now = 1'b1;
            end
            S_JUMP: begin
                done_now = (r_idx == JUMP_LAST);
            end
            default: begin
                done_now = 1'b0;
            end
        endcase
        if (done_now) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the xoshiro256++ generator: a directed table, then random traffic.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import xsr_pkg::*;

    typedef struct packed {
        t_word value;
        t_word fork0;
        t_word fork1;
        t_word fork2;
        t_word fork3;
    } t_gen_result;

    typedef struct {
        t_op         op;
        t_word       seed;
        t_word       range_low;
        t_word       range_high;
        bit          typed;
        t_gen_result want;
    } t_cmd_row;

    localparam t_word       WORD_MAX   = 64'hffff_ffff_ffff_ffff;
    localparam t_word       SEED_PAT   = 64'h0123_4567_89ab_cdef;
    localparam t_gen_result NO_RESULT  = '0;
    localparam int          N_DIRECTED = 23;
    localparam int          N_RANDOM   = 2000;
    localparam int          N_PHASES   = 4;
    localparam int          HOLD_LEN   = 400;
    localparam int          DRAIN_LEN  = 300;

    localparam t_word JUMP_TAPS [4] = '{
        64'h180ec6d33cfd0aba, 64'hd5a61266f0c9392c,
        64'ha9582618e03fc9aa, 64'h39abdc4529b1661c
    };

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op           = 2'd0;
    logic [63:0] i_seed         = '0;
    logic [63:0] i_range_low    = '0;
    logic [63:0] i_range_high   = '0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [63:0] o_value;
    logic [63:0] o_forked_word0;
    logic [63:0] o_forked_word1;
    logic [63:0] o_forked_word2;
    logic [63:0] o_forked_word3;

    t_word       gen_words [4] = '{default: '0};
    t_gen_result pending_results [$];
    t_gen_result oldest_result;
    int          mismatches      = 0;
    int          send_idle_pct   = 0;
    int          ready_stall_pct = 0;
    int          hold_req        = 0;
    int          hold_left       = 0;

    t_cmd_row directed_cmds [N_DIRECTED] = '{
        '{OP_NEXT,   '0,       '0,           '0,           1'b1, NO_RESULT},
        '{OP_FORK,   '0,       '0,           '0,           1'b1, NO_RESULT},
        '{OP_RANGED, '0,       64'd5,        64'd5,        1'b1, '{64'd5, '0, '0, '0, '0}},
        '{OP_RANGED, '0,       WORD_MAX,     '0,           1'b1, '{WORD_MAX, '0, '0, '0, '0}},
        '{OP_RANGED, '0,       '0,           WORD_MAX,     1'b1, NO_RESULT},
        '{OP_SEED,   '0,       '0,           '0,           1'b1, NO_RESULT},
        '{OP_NEXT,   '0,       '0,           '0,           1'b1, NO_RESULT},
        '{OP_SEED,   WORD_MAX, '0,           '0,           1'b1, NO_RESULT},
        '{OP_FORK,   '0,       '0,           '0,           1'b1,
          '{'0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX}},
        '{OP_NEXT,   '0,       '0,           '0,           1'b0, NO_RESULT},
        '{OP_RANGED, '0,       '0,           WORD_MAX,     1'b0, NO_RESULT},
        '{OP_RANGED, '0,       64'd10,       64'd20,       1'b0, NO_RESULT},
        '{OP_RANGED, '0,       '0,           64'd1,        1'b0, NO_RESULT},
        '{OP_RANGED, '0,       WORD_MAX - 1, WORD_MAX,     1'b0, NO_RESULT},
        '{OP_RANGED, '0,       '0,           WORD_MAX - 1, 1'b0, NO_RESULT},
        '{OP_RANGED, '0,       64'd1,        WORD_MAX,     1'b0, NO_RESULT},
        '{OP_SEED,   SEED_PAT, '0,           '0,           1'b1, NO_RESULT},
        '{OP_FORK,   '0,       '0,           '0,           1'b1,
          '{'0, SEED_PAT, SEED_PAT, SEED_PAT, SEED_PAT}},
        '{OP_NEXT,   '0,       '0,           '0,           1'b0, NO_RESULT},
        '{OP_RANGED, '0,       64'd100,      64'd99,       1'b1, '{64'd100, '0, '0, '0, '0}},
        '{OP_FORK,   '0,       '0,           '0,           1'b0, NO_RESULT},
        '{OP_SEED,   64'd1,    '0,           '0,           1'b1, NO_RESULT},
        '{OP_NEXT,   '0,       '0,           '0,           1'b0, NO_RESULT}
    };

    xoshiro256pp_generator_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_seed         (i_seed),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_value        (o_value),
        .o_forked_word0 (o_forked_word0),
        .o_forked_word1 (o_forked_word1),
        .o_forked_word2 (o_forked_word2),
        .o_forked_word3 (o_forked_word3)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_word rotl(t_word v, int unsigned n);
        return (v << n) | (v >> (64 - n));
    endfunction

    function automatic t_word gen_advance();
        t_word out;
        t_word t;
        out = rotl(gen_words[0] + gen_words[3], 23) + gen_words[0];
        t = gen_words[1] << 17;
        gen_words[2] = gen_words[2] ^ gen_words[0];
        gen_words[3] = gen_words[3] ^ gen_words[1];
        gen_words[1] = gen_words[1] ^ gen_words[2];
        gen_words[0] = gen_words[0] ^ gen_words[3];
        gen_words[2] = gen_words[2] ^ t;
        gen_words[3] = rotl(gen_words[3], 45);
        return out;
    endfunction

    function automatic void gen_jump();
        t_word acc [4];
        int    w;
        int    b;
        int    j;
        acc = '{default: '0};
        for (w = 0; w < 4; w++) begin
            for (b = 0; b < 64; b++) begin
                if (JUMP_TAPS[w][b]) begin
                    for (j = 0; j < 4; j++) begin
                        acc[j] = acc[j] ^ gen_words[j];
                    end
                end
                void'(gen_advance());
            end
        end
        gen_words = acc;
    endfunction

    function automatic t_gen_result predict_result(t_op op, t_word seed, t_word lo, t_word hi);
        t_gen_result r;
        t_word       span;
        int          k;
        r = NO_RESULT;
        case (op)
            OP_SEED: begin
                for (k = 0; k < 4; k++) begin
                    gen_words[k] = seed;
                end
            end
            OP_NEXT: begin
                r.value = gen_advance();
            end
            OP_RANGED: begin
                if (lo >= hi) begin
                    r.value = lo;
                end else begin
                    span = hi - lo + 64'd1;
                    if (span == '0) begin
                        r.value = gen_advance();
                    end else begin
                        r.value = (gen_advance() % span) + lo;
                    end
                end
            end
            default: begin
                r.fork0 = gen_words[0];
                r.fork1 = gen_words[1];
                r.fork2 = gen_words[2];
                r.fork3 = gen_words[3];
                gen_jump();
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, t_word want, t_word got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_cmd(input t_op op, input t_word seed, input t_word lo, input t_word hi,
                            input bit typed, input t_gen_result want);
        t_gen_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_seed       <= seed;
        i_range_low  <= lo;
        i_range_high <= hi;
        do @(posedge i_clk); while (!o_ready);
        predicted = predict_result(op, seed, lo, hi);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic send_random_cmd();
        int unsigned pick;
        t_op         op;
        t_word       seed;
        t_word       lo;
        t_word       hi;
        t_word       tmp;
        pick = $urandom_range(99);
        seed = {$urandom, $urandom};
        lo   = {$urandom, $urandom};
        hi   = {$urandom, $urandom};
        if (pick < 5) begin
            op = OP_SEED;
        end else if (pick < 50) begin
            op = OP_NEXT;
        end else if (pick < 92) begin
            op = OP_RANGED;
        end else begin
            op = OP_FORK;
        end
        if ($urandom_range(19) == 0) begin
            seed = '0;
        end
        case ($urandom_range(9))
            0: begin
                if (lo < hi) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end
            1: begin
                lo = '0;
                hi = WORD_MAX;
            end
            2, 3, 4: begin
                hi = lo + $urandom_range(1000, 1);
            end
            5: begin
                hi = lo + ((64'd1 << $urandom_range(63, 1)) - 64'd1);
            end
            6, 7: begin
                if (lo > hi) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end
            default: begin
            end
        endcase
        send_cmd(op, seed, lo, hi, 1'b0, NO_RESULT);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no transaction pending, expected none, actual %h",
                         $time, o_value);
                mismatches++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("value", oldest_result.value, o_value);
                check_field("forked_word0", oldest_result.fork0, o_forked_word0);
                check_field("forked_word1", oldest_result.fork1, o_forked_word1);
                check_field("forked_word2", oldest_result.fork2, o_forked_word2);
                check_field("forked_word3", oldest_result.fork3, o_forked_word3);
            end
        end
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    initial begin
        int k;
        int ph;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (k = 0; k < N_DIRECTED; k++) begin
            send_cmd(directed_cmds[k].op, directed_cmds[k].seed, directed_cmds[k].range_low,
                     directed_cmds[k].range_high, directed_cmds[k].typed,
                     directed_cmds[k].want);
        end
        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct   = 0;
                    ready_stall_pct = 0;
                end
                1: begin
                    send_idle_pct   = 78;
                    ready_stall_pct = 0;
                end
                2: begin
                    send_idle_pct   = 0;
                    ready_stall_pct = 78;
                end
                default: begin
                    send_idle_pct   = 11;
                    ready_stall_pct = 11;
                end
            endcase
            for (k = 0; k < N_RANDOM / N_PHASES; k++) begin
                if (ph == 0 && k == 100) begin
                    hold_req = HOLD_LEN;
                end
                send_random_cmd();
            end
        end
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("tb: failure");
        $finish;
    end

endmodule
